// File: hw/rtl/tce_pkg.sv
// Shared types and constants for the toy CPU execute step.
// Holds the operation codes, the instruction advance and the structs passed
// between the execute logic, the register file and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

  localparam logic [31:0] INSN_BYTES = 32'd4;

  typedef enum logic [3:0] {
    OP_MOV = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_CMP = 4'd3,
    OP_B   = 4'd4,
    OP_BEQ = 4'd5,
    OP_BNE = 4'd6,
    OP_BGE = 4'd7,
    OP_BGT = 4'd8,
    OP_BLE = 4'd9,
    OP_BLT = 4'd10
  } op_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] idx_a;
    logic [3:0] idx_b;
  } rf_rd_req_t;

  typedef struct packed {
    logic        wr_en;
    logic [3:0]  idx;
    logic [31:0] data;
  } rf_wr_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] result;
    logic        flag_z;
    logic        flag_n;
    logic        taken;
    logic        fault;
    logic        rd_write;
  } exec_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/tce_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on nothing; the testbench instantiates them for the top level.
`timescale 1ns / 1ps
`default_nettype none

interface tce_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic [3:0]         dest_reg;
  logic [3:0]         first_reg;
  logic [3:0]         second_reg;
  logic               use_immediate;
  logic [11:0]        immediate_value;
  logic signed [23:0] branch_offset;

  modport source (
    output valid, operation, dest_reg, first_reg, second_reg,
           use_immediate, immediate_value, branch_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_reg, first_reg, second_reg,
           use_immediate, immediate_value, branch_offset,
    output ready
  );
endinterface

interface tce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [31:0] result_value;
  logic        flag_zero;
  logic        flag_negative;
  logic        branch_taken;
  logic        fault;

  modport source (
    output valid, next_pc, result_value, flag_zero, flag_negative,
           branch_taken, fault,
    input  ready
  );
  modport sink (
    input  valid, next_pc, result_value, flag_zero, flag_negative,
           branch_taken, fault,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/toy_cpu_execute_step.sv
// Top level of the toy CPU execute step: input register, register file,
// execute logic, PC and flag registers and the result register.
// Depends on tce_pkg, tce_if, tce_regfile and tce_exec.
//
// Each accepted instruction beat is executed from the input register, and its
// result beat is presented from the result register. Throughput is one
// instruction per cycle while the result channel does not stall, set by the
// single execute stage that reads the register file and writes back the PC,
// flags and destination in the same cycle. A result waiting on the output
// blocks the next instruction from entering the input register once that
// register is full. All registers and flags read as zero after reset; reading
// the PC register yields the address of the current instruction, and a write
// to the PC register is replaced by the normal advance by four.
`timescale 1ns / 1ps
`default_nettype none

module toy_cpu_execute_step
  import tce_pkg::*;
#(
  parameter int REGISTER_COUNT = 16,
  parameter int PC_INDEX       = 15
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tce_in_if.sink    in_ch,
  tce_out_if.source out_ch
);

  localparam int PC_SLOT = PC_INDEX % REGISTER_COUNT;

  logic               stg_valid_r;
  logic [3:0]         stg_op_r, stg_rd_r, stg_rn_r, stg_rm_r;
  logic               stg_imm_r;
  logic [11:0]        stg_immv_r;
  logic signed [23:0] stg_off_r;

  logic [31:0] pc_r;
  logic        zero_r, neg_r;

  logic        out_valid_r;
  exec_res_t   out_res_r;

  logic        in_fire, stg_fire;
  logic        rn_is_pc, rm_is_pc, rd_is_pc;
  logic [31:0] rf_a, rf_b, opa, opb_reg;
  rf_rd_req_t  rd_req;
  rf_wr_req_t  wr_req;
  exec_res_t   res;

  assign stg_fire     = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !stg_valid_r || stg_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign rn_is_pc = {28'd0, stg_rn_r} == 32'(PC_SLOT);
  assign rm_is_pc = {28'd0, stg_rm_r} == 32'(PC_SLOT);
  assign rd_is_pc = {28'd0, stg_rd_r} == 32'(PC_SLOT);

  assign rd_req.rd_en = in_fire;
  assign rd_req.idx_a = in_ch.first_reg;
  assign rd_req.idx_b = in_ch.second_reg;

  assign wr_req.wr_en = stg_fire && res.rd_write && !rd_is_pc;
  assign wr_req.idx   = stg_rd_r;
  assign wr_req.data  = res.result;

  tce_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rdata_a(rf_a),
    .rdata_b(rf_b)
  );

  assign opa     = rn_is_pc ? pc_r : rf_a;
  assign opb_reg = rm_is_pc ? pc_r : rf_b;

  tce_exec u_exec (
    .operation      (stg_op_r),
    .use_immediate  (stg_imm_r),
    .immediate_value(stg_immv_r),
    .branch_offset  (stg_off_r),
    .opa            (opa),
    .opb_reg        (opb_reg),
    .pc             (pc_r),
    .zero_flag      (zero_r),
    .negative_flag  (neg_r),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_op_r   <= in_ch.operation;
      stg_rd_r   <= in_ch.dest_reg;
      stg_rn_r   <= in_ch.first_reg;
      stg_rm_r   <= in_ch.second_reg;
      stg_imm_r  <= in_ch.use_immediate;
      stg_immv_r <= in_ch.immediate_value;
      stg_off_r  <= in_ch.branch_offset;
    end
    if (stg_fire) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= 32'd0;
      zero_r      <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        stg_valid_r <= 1'b1;
      end else if (stg_fire) begin
        stg_valid_r <= 1'b0;
      end
      if (stg_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (stg_fire && !res.fault) begin
        pc_r   <= res.next_pc;
        zero_r <= res.flag_z;
        neg_r  <= res.flag_n;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_pc       = out_res_r.next_pc;
  assign out_ch.result_value  = out_res_r.result;
  assign out_ch.flag_zero     = out_res_r.flag_z;
  assign out_ch.flag_negative = out_res_r.flag_n;
  assign out_ch.branch_taken  = out_res_r.taken;
  assign out_ch.fault         = out_res_r.fault;

endmodule

`default_nettype wire

// File: hw/rtl/tce_regfile.sv
// General register file: a two-read, one-write memory with registered reads,
// per-entry valid bits for the all-zero reset and a write-to-read bypass.
// Depends on tce_pkg for the request structs.
`timescale 1ns / 1ps
`default_nettype none

module tce_regfile
  import tce_pkg::*;
#(
  parameter int REGISTER_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rf_rd_req_t  rd_req,
  input  wire rf_wr_req_t  wr_req,
  output logic [31:0]      rdata_a,
  output logic [31:0]      rdata_b
);

  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [31:0]               mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_r;
  logic [31:0]               q_a_r, q_b_r, byp_data_r;
  logic                      hit_a_r, hit_b_r, ok_a_r, ok_b_r;

  logic             rng_a, rng_b, rng_w, we;
  logic [IDX_W-1:0] addr_a, addr_b, addr_w;

  assign rng_a  = {28'd0, rd_req.idx_a} < 32'(REGISTER_COUNT);
  assign rng_b  = {28'd0, rd_req.idx_b} < 32'(REGISTER_COUNT);
  assign rng_w  = {28'd0, wr_req.idx} < 32'(REGISTER_COUNT);
  assign addr_a = IDX_W'(rd_req.idx_a);
  assign addr_b = IDX_W'(rd_req.idx_b);
  assign addr_w = IDX_W'(wr_req.idx);
  assign we     = wr_req.wr_en && rng_w;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_w] <= wr_req.data;
    end
    if (rd_req.rd_en) begin
      q_a_r      <= mem[addr_a];
      q_b_r      <= mem[addr_b];
      byp_data_r <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
      ok_a_r  <= 1'b0;
      ok_b_r  <= 1'b0;
    end else begin
      if (we) begin
        valid_r[addr_w] <= 1'b1;
      end
      if (rd_req.rd_en) begin
        hit_a_r <= rng_a && we && (addr_w == addr_a);
        hit_b_r <= rng_b && we && (addr_w == addr_b);
        ok_a_r  <= rng_a && valid_r[addr_a];
        ok_b_r  <= rng_b && valid_r[addr_b];
      end
    end
  end

  assign rdata_a = hit_a_r ? byp_data_r : (ok_a_r ? q_a_r : 32'd0);
  assign rdata_b = hit_b_r ? byp_data_r : (ok_b_r ? q_b_r : 32'd0);

endmodule

`default_nettype wire

// File: hw/rtl/tce_exec.sv
// Execute logic for one instruction: operand select, add or subtract, flag
// update, branch condition and next PC. Purely combinational; uses tce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tce_exec
  import tce_pkg::*;
(
  input  wire logic [3:0]         operation,
  input  wire logic               use_immediate,
  input  wire logic [11:0]        immediate_value,
  input  wire logic signed [23:0] branch_offset,
  input  wire logic [31:0]        opa,
  input  wire logic [31:0]        opb_reg,
  input  wire logic [31:0]        pc,
  input  wire logic               zero_flag,
  input  wire logic               negative_flag,
  output exec_res_t               res
);

  logic [31:0] opb, sum, diff, off_ext, pc_adv;
  logic        cond;

  assign opb     = use_immediate ? {20'd0, immediate_value} : opb_reg;
  assign sum     = opa + opb;
  assign diff    = opa - opb;
  assign off_ext = {{8{branch_offset[23]}}, branch_offset};
  assign pc_adv  = pc + INSN_BYTES;

  always_comb begin
    res          = '0;
    res.next_pc  = pc_adv;
    res.flag_z   = zero_flag;
    res.flag_n   = negative_flag;
    cond         = 1'b0;
    case (op_t'(operation))
      OP_MOV: begin
        res.result   = opb;
        res.rd_write = 1'b1;
      end
      OP_ADD: begin
        res.result   = sum;
        res.rd_write = 1'b1;
        res.flag_z   = (sum == 32'd0);
        res.flag_n   = sum[31];
      end
      OP_SUB: begin
        res.result   = diff;
        res.rd_write = 1'b1;
        res.flag_z   = (diff == 32'd0);
        res.flag_n   = diff[31];
      end
      OP_CMP: begin
        res.result = diff;
        res.flag_z = (diff == 32'd0);
        res.flag_n = diff[31];
      end
      OP_B:   cond = 1'b1;
      OP_BEQ: cond = zero_flag;
      OP_BNE: cond = !zero_flag;
      OP_BGE: cond = !negative_flag;
      OP_BGT: cond = !zero_flag && !negative_flag;
      OP_BLE: cond = zero_flag || negative_flag;
      OP_BLT: cond = negative_flag;
      default: begin
        res.fault   = 1'b1;
        res.next_pc = pc;
      end
    endcase
    if (cond) begin
      res.taken   = 1'b1;
      res.next_pc = pc + off_ext;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tce_checker.sv
// Port-level checks for the toy CPU execute step, attached by bind.
// Watches only the result channel of toy_cpu_execute_step.
`timescale 1ns / 1ps
`default_nettype none

module tce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] next_pc,
  input wire logic [31:0] result_value,
  input wire logic        branch_taken,
  input wire logic        fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(next_pc) && $stable(result_value))
    else $error("Result payload changed while stalled.");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault |-> !branch_taken && result_value == 32'd0)
    else $error("Faulting instruction reported a branch or a result.");

  a_branch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && branch_taken |-> !fault && result_value == 32'd0)
    else $error("Taken branch reported a nonzero result.");

endmodule

bind toy_cpu_execute_step tce_checker u_tce_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .next_pc     (out_ch.next_pc),
  .result_value(out_ch.result_value),
  .branch_taken(out_ch.branch_taken),
  .fault       (out_ch.fault)
);

`default_nettype wire

// File: tb/toy_cpu_execute_step_test.sv
// Self-checking testbench for the toy CPU execute step (toy_cpu_execute_step).
// Depends on tce_pkg, tce_if and the top level from the RTL; predicts each
// result beat that is not typed in from its own copy of the register file and flags.
`timescale 1ns / 1ps

module toy_cpu_execute_step_test;
  import tce_pkg::*;

  localparam int REG_COUNT = 16;
  localparam int PC_SLOT = 15;
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
  localparam logic [3:0] OP_UNUSED_LAST = 4'd15;

  typedef struct packed {
    logic [3:0]         operation;
    logic [3:0]         dest_reg;
    logic [3:0]         first_reg;
    logic [3:0]         second_reg;
    logic               use_immediate;
    logic [11:0]        immediate_value;
    logic signed [23:0] branch_offset;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] result_value;
    logic        flag_zero;
    logic        flag_negative;
    logic        branch_taken;
    logic        fault;
  } result_beat_t;

  typedef struct packed {
    instr_t       instr;
    logic         has_want;
    result_beat_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  tce_in_if  in_ch ();
  tce_out_if out_ch ();

  toy_cpu_execute_step u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [31:0]  arch_regs [REG_COUNT];
  logic         zero_state = 1'b0;
  logic         negative_state = 1'b0;
  result_beat_t pending_results [$];
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;
  int           hold_cycles = 0;

  // The first rows start from reset, so their results are typed in directly.
  directed_row_t directed_rows [24] = '{
    '{'{OP_MOV, 4'd1, 4'd0, 4'd0, 1'b1, 12'hFFF, 24'h000000}, 1'b1,
      '{32'd4, 32'h0000_0FFF, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_UNUSED_FIRST, 4'd1, 4'd2, 4'd3, 1'b0, 12'h000, 24'h000000}, 1'b1,
      '{32'd4, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_UNUSED_LAST, 4'd15, 4'd15, 4'd15, 1'b1, 12'hFFF, 24'hFFFFFF}, 1'b1,
      '{32'd4, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_SUB, 4'd2, 4'd0, 4'd0, 1'b1, 12'h001, 24'h000000}, 1'b1,
      '{32'd8, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{OP_ADD, 4'd3, 4'd2, 4'd0, 1'b1, 12'h001, 24'h000000}, 1'b1,
      '{32'd12, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{OP_BNE, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h7FFFFF}, 1'b1,
      '{32'd16, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{'{OP_BEQ, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'hFFFFFC}, 1'b1,
      '{32'd12, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{'{OP_BLE, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000008}, 1'b0, '0},
    '{'{OP_BLT, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000100}, 1'b0, '0},
    '{'{OP_CMP, 4'd0, 4'd2, 4'd1, 1'b0, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_BLT, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000004}, 1'b0, '0},
    '{'{OP_BGE, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000040}, 1'b0, '0},
    '{'{OP_BLE, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000010}, 1'b0, '0},
    '{'{OP_BGT, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000020}, 1'b0, '0},
    '{'{OP_ADD, 4'd4, 4'd2, 4'd2, 1'b0, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_MOV, 4'd15, 4'd0, 4'd0, 1'b1, 12'h123, 24'h000000}, 1'b0, '0},
    '{'{OP_CMP, 4'd0, 4'd15, 4'd0, 1'b1, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_BGT, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h800000}, 1'b0, '0},
    '{'{OP_BGE, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h7FFFFF}, 1'b0, '0},
    '{'{OP_SUB, 4'd5, 4'd15, 4'd15, 1'b0, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_MOV, 4'd6, 4'd0, 4'd2, 1'b0, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_B, 4'd0, 4'd0, 4'd0, 1'b0, 12'h000, 24'h000000}, 1'b0, '0},
    '{'{OP_ADD, 4'd15, 4'd15, 4'd0, 1'b1, 12'hFFF, 24'h000000}, 1'b0, '0},
    '{'{OP_SUB, 4'd7, 4'd1, 4'd0, 1'b1, 12'hFFF, 24'h000000}, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    foreach (arch_regs[r]) arch_regs[r] = 32'd0;
  end

  function automatic result_beat_t execute_instruction(input instr_t beat);
    result_beat_t res;
    logic [31:0]  pc;
    logic [31:0]  operand_a;
    logic [31:0]  operand_b;
    logic         cond;
    pc = arch_regs[PC_SLOT];
    operand_a = arch_regs[beat.first_reg];
    operand_b = beat.use_immediate ? {20'd0, beat.immediate_value}
                                   : arch_regs[beat.second_reg];
    res = '0;
    res.next_pc = pc + INSN_BYTES;
    cond = 1'b0;
    case (beat.operation)
      OP_MOV: begin
        res.result_value = operand_b;
        arch_regs[beat.dest_reg] = res.result_value;
      end
      OP_ADD, OP_SUB, OP_CMP: begin
        res.result_value = (beat.operation == OP_ADD) ? operand_a + operand_b
                                                      : operand_a - operand_b;
        if (beat.operation != OP_CMP) arch_regs[beat.dest_reg] = res.result_value;
        zero_state = (res.result_value == 32'd0);
        negative_state = res.result_value[31];
      end
      OP_B:   cond = 1'b1;
      OP_BEQ: cond = zero_state;
      OP_BNE: cond = !zero_state;
      OP_BGE: cond = !negative_state;
      OP_BGT: cond = !zero_state && !negative_state;
      OP_BLE: cond = zero_state || negative_state;
      OP_BLT: cond = negative_state;
      default: begin
        res.fault = 1'b1;
        res.next_pc = pc;
      end
    endcase
    if (cond) begin
      res.branch_taken = 1'b1;
      res.next_pc = pc + {{8{beat.branch_offset[23]}}, beat.branch_offset};
    end
    // A write to the PC slot by MOV, ADD or SUB is replaced by the advance.
    if (!res.fault) arch_regs[PC_SLOT] = res.next_pc;
    res.flag_zero = zero_state;
    res.flag_negative = negative_state;
    return res;
  endfunction

  function automatic instr_t random_instruction();
    instr_t beat;
    beat.dest_reg = 4'($urandom_range(15, 0));
    beat.first_reg = 4'($urandom_range(15, 0));
    beat.second_reg = 4'($urandom_range(15, 0));
    beat.use_immediate = 1'($urandom_range(1, 0));
    if ($urandom_range(99) < 8) begin
      beat.operation = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    end else begin
      beat.operation = 4'($urandom_range(OP_BLT, OP_MOV));
    end
    case ($urandom_range(7))
      0: beat.immediate_value = 12'h000;
      1: beat.immediate_value = 12'hFFF;
      default: beat.immediate_value = 12'($urandom());
    endcase
    case ($urandom_range(7))
      0: beat.branch_offset = 24'h800000;
      1: beat.branch_offset = 24'h7FFFFF;
      2: beat.branch_offset = 24'h000000;
      default: beat.branch_offset = 24'($urandom());
    endcase
    // Subtracting a register from itself gives the zero flag regular exercise.
    if ((beat.operation == OP_SUB || beat.operation == OP_CMP) &&
        $urandom_range(3) == 0) begin
      beat.use_immediate = 1'b0;
      beat.second_reg = beat.first_reg;
    end
    return beat;
  endfunction

  task automatic send_beat(input instr_t beat, input logic has_want,
                           input result_beat_t want);
    result_beat_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= beat.operation;
    in_ch.dest_reg <= beat.dest_reg;
    in_ch.first_reg <= beat.first_reg;
    in_ch.second_reg <= beat.second_reg;
    in_ch.use_immediate <= beat.use_immediate;
    in_ch.immediate_value <= beat.immediate_value;
    in_ch.branch_offset <= beat.branch_offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = execute_instruction(beat);
    pending_results.push_back(has_want ? want : predicted);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int send_pct, input int stall_pct);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_beat(random_instruction(), 1'b0, '0);
    drain_results();
  endtask

  initial begin
    result_beat_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no instruction outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, actual %h", want.next_pc, out_ch.next_pc);
            mismatch_count++;
          end
          if (out_ch.result_value !== want.result_value) begin
            $error("result_value: expected %h, actual %h", want.result_value,
                   out_ch.result_value);
            mismatch_count++;
          end
          if (out_ch.flag_zero !== want.flag_zero) begin
            $error("flag_zero: expected %b, actual %b", want.flag_zero, out_ch.flag_zero);
            mismatch_count++;
          end
          if (out_ch.flag_negative !== want.flag_negative) begin
            $error("flag_negative: expected %b, actual %b", want.flag_negative,
                   out_ch.flag_negative);
            mismatch_count++;
          end
          if (out_ch.branch_taken !== want.branch_taken) begin
            $error("branch_taken: expected %b, actual %b", want.branch_taken,
                   out_ch.branch_taken);
            mismatch_count++;
          end
          if (out_ch.fault !== want.fault) begin
            $error("fault: expected %b, actual %b", want.fault, out_ch.fault);
            mismatch_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.dest_reg = '0;
    in_ch.first_reg = '0;
    in_ch.second_reg = '0;
    in_ch.use_immediate = 1'b0;
    in_ch.immediate_value = '0;
    in_ch.branch_offset = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].instr, directed_rows[r].has_want, directed_rows[r].want);
    end
    drain_results();

    run_phase(150, 0, 0);
    run_phase(150, 74, 0);
    run_phase(150, 0, 74);
    run_phase(150, 31, 31);

    // The output stays blocked long enough for the block to stall its input.
    hold_cycles = 60;
    run_phase(40, 0, 0);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: toy_cpu_execute_step.f
hw/rtl/tce_pkg.sv
hw/rtl/tce_if.sv
hw/rtl/tce_regfile.sv
hw/rtl/tce_exec.sv
hw/rtl/toy_cpu_execute_step.sv
hw/rtl/tce_checker.sv
tb/toy_cpu_execute_step_test.sv
